### hw/rtl/cet_pkg.sv
// Shared constants, codes and types of the completion event tracker.
`default_nettype none

package cet_pkg;

   localparam int RING_DEPTH = 1024;

   localparam int REQ_W    = 3;
   localparam int IDX_W    = 12;
   localparam int LEN_W    = 16;
   localparam int FLG_W    = 16;
   localparam int CODE_W   = 8;
   localparam int CNT_W    = 13;
   localparam int PTR_W    = 32;
   localparam int STATUS_W = 3;

   localparam int SLOT_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int ENTRY_W   = LEN_W + FLG_W;
   localparam int MOD_STEPS = IDX_W - SLOT_W + 1;
   localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
   localparam int DIV_W     = 2 * IDX_W + 1;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REQ_W-1:0] REQ_INIT  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_RX    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_TX    = 3'd2;
   localparam logic [REQ_W-1:0] REQ_EXC   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ABORT       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ABORT   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_ORD  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IGN_IN_EXC  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TX_IGNORED  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_EXC_IGNORED = 3'd6;

   localparam logic [REG_IDX_W-1:0] REG_RX_MASK  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TX_MASK  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_MAX_BAT  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DISCARD  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CONTINUE = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_IGN_CODE = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_TX_EN    = 3'd6;

   typedef struct packed {
      logic [IDX_W-1:0]  rx_ring_mask;
      logic [IDX_W-1:0]  tx_ring_mask;
      logic [CNT_W-1:0]  max_batch;
      logic [FLG_W-1:0]  discard_mask;
      logic [FLG_W-1:0]  continue_mask;
      logic [CODE_W-1:0] ignored_exception_code;
      logic              tx_enabled;
   } cfg_type;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [IDX_W-1:0]  desc_index;
      logic [LEN_W-1:0]  length;
      logic [FLG_W-1:0]  pkt_flags;
      logic [CODE_W-1:0] exception_code;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    completed_count;
      logic [PTR_W-1:0]    rx_pending_count;
      logic [PTR_W-1:0]    tx_pending_count;
      logic                exception_state;
      logic                started_state;
      logic [FLG_W-1:0]    desc_flags_out;
      logic [LEN_W-1:0]    desc_size_out;
   } rsp_item_type;

endpackage

`default_nettype wire

### hw/rtl/cet_regs.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module cet_regs
   import cet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_hit;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_hit  = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         case (reg_idx)
            REG_RX_MASK:  cfg_in.rx_ring_mask           = pwdata[IDX_W-1:0];
            REG_TX_MASK:  cfg_in.tx_ring_mask           = pwdata[IDX_W-1:0];
            REG_MAX_BAT:  cfg_in.max_batch              = pwdata[CNT_W-1:0];
            REG_DISCARD:  cfg_in.discard_mask           = pwdata[FLG_W-1:0];
            REG_CONTINUE: cfg_in.continue_mask          = pwdata[FLG_W-1:0];
            REG_IGN_CODE: cfg_in.ignored_exception_code = pwdata[CODE_W-1:0];
            REG_TX_EN:    cfg_in.tx_enabled             = pwdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_RX_MASK:  prdata = CSR_DATA_W'(cfg_ff.rx_ring_mask);
         REG_TX_MASK:  prdata = CSR_DATA_W'(cfg_ff.tx_ring_mask);
         REG_MAX_BAT:  prdata = CSR_DATA_W'(cfg_ff.max_batch);
         REG_DISCARD:  prdata = CSR_DATA_W'(cfg_ff.discard_mask);
         REG_CONTINUE: prdata = CSR_DATA_W'(cfg_ff.continue_mask);
         REG_IGN_CODE: prdata = CSR_DATA_W'(cfg_ff.ignored_exception_code);
         REG_TX_EN:    prdata = CSR_DATA_W'(cfg_ff.tx_enabled);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rx_ring_mask           <= IDX_W'(1023);
         cfg_ff.tx_ring_mask           <= IDX_W'(1023);
         cfg_ff.max_batch              <= CNT_W'(64);
         cfg_ff.discard_mask           <= FLG_W'(1);
         cfg_ff.continue_mask          <= FLG_W'(2);
         cfg_ff.ignored_exception_code <= '0;
         cfg_ff.tx_enabled             <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/cet_desc_ram.sv
// Single-port-write, single-port-read descriptor memory with registered read data.
`default_nettype none

module cet_desc_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/cet_ctrl.sv
// Event sequencer: decodes each item, walks the descriptor memory and builds the result.
`default_nettype none

module cet_ctrl
   import cet_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_item_type       req_item,
   output logic               rsp_strobe,
   output rsp_item_type       rsp_item,
   input  cfg_type            cfg,
   output logic               mem_wr_en,
   output logic [SLOT_W-1:0]  mem_wr_addr,
   output logic [ENTRY_W-1:0] mem_wr_data,
   output logic               mem_rd_en,
   output logic [SLOT_W-1:0]  mem_rd_addr,
   input  logic [ENTRY_W-1:0] mem_rd_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EVAL  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_WRITE = 3'd3;
   localparam logic [2:0] S_ARD   = 3'd4;
   localparam logic [2:0] S_AWR   = 3'd5;
   localparam logic [2:0] S_RRD   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   function automatic logic [CNT_W-1:0] ring_dist(
      input logic [IDX_W-1:0] idx,
      input logic [IDX_W-1:0] pend,
      input logic [IDX_W-1:0] mask
   );
      logic [IDX_W-1:0] stop_v;
      logic [IDX_W-1:0] begin_v;
      stop_v  = (idx + IDX_W'(1)) & mask;
      begin_v = pend & mask;
      if (stop_v >= begin_v) begin
         return CNT_W'(stop_v - begin_v);
      end
      return CNT_W'(mask) + CNT_W'(1) - CNT_W'(begin_v) + CNT_W'(stop_v);
   endfunction

   logic [2:0]          st_ff, st_in;
   logic [2:0]          nxt_ff, nxt_in;
   req_item_type        req_ff, req_in;
   logic [IDX_W-1:0]    red_ff, red_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [IDX_W-1:0]    ring_ff, ring_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    done_ff, done_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [PTR_W-1:0]    rxp_ff, rxp_in;
   logic [PTR_W-1:0]    txp_ff, txp_in;
   logic                exc_ff, exc_in;
   logic                started_ff, started_in;
   logic                phase_ff, phase_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff, rsp_in;

   logic [CNT_W-1:0]    rx_d;
   logic [CNT_W-1:0]    tx_d;
   logic [IDX_W-1:0]    rx_begin;
   logic [IDX_W-1:0]    ring_next;
   logic [IDX_W-1:0]    slot_next;
   logic [DIV_W-1:0]    mod_div;
   logic                mod_ge;
   logic                is_read;

   assign rx_d      = ring_dist(req_ff.desc_index, rxp_ff[IDX_W-1:0], cfg.rx_ring_mask);
   assign tx_d      = ring_dist(req_ff.desc_index, txp_ff[IDX_W-1:0], cfg.tx_ring_mask);
   assign rx_begin  = rxp_ff[IDX_W-1:0] & cfg.rx_ring_mask;
   assign ring_next = (ring_ff + IDX_W'(1)) & cfg.rx_ring_mask;
   assign slot_next = IDX_W'(DIV_W'(ring_next) % DIV_W'(RING_DEPTH));
   assign mod_div   = DIV_W'(RING_DEPTH) << step_ff;
   assign mod_ge    = DIV_W'(red_ff) >= mod_div;
   assign is_read   = (req_ff.req_type == REQ_READ);

   assign busy        = (st_ff != S_IDLE);
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_item    = rsp_ff;

   assign mem_wr_en   = (st_ff == S_WRITE) || (st_ff == S_AWR);
   assign mem_wr_addr = red_ff[SLOT_W-1:0];
   assign mem_rd_en   = (st_ff == S_ARD) || (st_ff == S_RRD);
   assign mem_rd_addr = red_ff[SLOT_W-1:0];

   always_comb begin
      if (st_ff == S_AWR) begin
         if (phase_ff) begin
            mem_wr_data = mem_rd_data & {{LEN_W{1'b1}}, ~cfg.continue_mask};
         end else begin
            mem_wr_data = mem_rd_data | {{LEN_W{1'b0}}, cfg.discard_mask};
         end
      end else begin
         mem_wr_data = {req_ff.length, req_ff.pkt_flags};
      end
   end

   always_comb begin
      st_in        = st_ff;
      nxt_in       = nxt_ff;
      req_in       = req_ff;
      red_in       = red_ff;
      step_in      = step_ff;
      ring_in      = ring_ff;
      cnt_in       = cnt_ff;
      done_in      = done_ff;
      status_in    = status_ff;
      rxp_in       = rxp_ff;
      txp_in       = txp_ff;
      exc_in       = exc_ff;
      started_in   = started_ff;
      phase_in     = phase_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      case (st_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               st_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            status_in = ST_OK;
            done_in   = '0;
            step_in   = STEP_W'(MOD_STEPS - 1);
            st_in     = S_DONE;
            case (req_ff.req_type)
               REQ_INIT: begin
                  started_in = 1'b1;
               end
               REQ_RX: begin
                  if (exc_ff) begin
                     status_in = ST_IGN_IN_EXC;
                  end else if (rx_d == '0) begin
                     if (req_ff.length != '0) begin
                        exc_in    = 1'b1;
                        status_in = ST_BAD_ABORT;
                     end else begin
                        status_in = ST_ABORT;
                        red_in    = rx_begin;
                        phase_in  = 1'b0;
                        nxt_in    = S_ARD;
                        st_in     = S_MOD;
                     end
                  end else if (rx_d > cfg.max_batch) begin
                     exc_in    = 1'b1;
                     status_in = ST_OUT_OF_ORD;
                  end else begin
                     red_in  = rx_begin;
                     ring_in = rx_begin;
                     cnt_in  = rx_d;
                     done_in = rx_d;
                     rxp_in  = rxp_ff + PTR_W'(rx_d);
                     nxt_in  = S_WRITE;
                     st_in   = S_MOD;
                  end
               end
               REQ_TX: begin
                  if (!cfg.tx_enabled) begin
                     status_in = ST_TX_IGNORED;
                  end else begin
                     txp_in  = txp_ff + PTR_W'(tx_d);
                     done_in = tx_d;
                  end
               end
               REQ_EXC: begin
                  if (req_ff.exception_code == cfg.ignored_exception_code) begin
                     status_in = ST_EXC_IGNORED;
                  end else begin
                     exc_in = 1'b1;
                  end
               end
               REQ_READ: begin
                  red_in = req_ff.desc_index;
                  nxt_in = S_RRD;
                  st_in  = S_MOD;
               end
               REQ_CLEAR: begin
                  exc_in = 1'b0;
               end
               default: begin
                  st_in = S_DONE;
               end
            endcase
         end
         S_MOD: begin
            if (mod_ge) begin
               red_in = red_ff - mod_div[IDX_W-1:0];
            end
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               st_in = nxt_ff;
            end
         end
         S_WRITE: begin
            ring_in = ring_next;
            red_in  = slot_next;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               st_in = S_DONE;
            end
         end
         S_ARD: begin
            st_in = S_AWR;
         end
         S_AWR: begin
            if (phase_ff) begin
               st_in = S_DONE;
            end else begin
               phase_in = 1'b1;
               red_in   = req_ff.desc_index & cfg.rx_ring_mask;
               step_in  = STEP_W'(MOD_STEPS - 1);
               nxt_in   = S_ARD;
               st_in    = S_MOD;
            end
         end
         S_RRD: begin
            st_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in           = 1'b1;
            rsp_in.status          = status_ff;
            rsp_in.completed_count = done_ff;
            rsp_in.rx_pending_count = rxp_ff;
            rsp_in.tx_pending_count = txp_ff;
            rsp_in.exception_state = exc_ff;
            rsp_in.started_state   = started_ff;
            rsp_in.desc_flags_out  = is_read ? mem_rd_data[FLG_W-1:0] : '0;
            rsp_in.desc_size_out   = is_read ? mem_rd_data[ENTRY_W-1:FLG_W] : '0;
            st_in                  = S_IDLE;
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         rxp_ff       <= '0;
         txp_ff       <= '0;
         exc_ff       <= 1'b0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rxp_ff       <= rxp_in;
         txp_ff       <= txp_in;
         exc_ff       <= exc_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nxt_ff    <= nxt_in;
      req_ff    <= req_in;
      red_ff    <= red_in;
      step_ff   <= step_in;
      ring_ff   <= ring_in;
      cnt_ff    <= cnt_in;
      done_ff   <= done_in;
      status_ff <= status_in;
      phase_ff  <= phase_in;
      rsp_ff    <= rsp_in;
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(st_ff == S_DONE))
      else $error("result issued outside the completion step");

   a_wr_addr_range: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (int'(mem_wr_addr) < RING_DEPTH))
      else $error("descriptor write beyond the memory");

   a_no_rd_wr: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("memory read and write in the same cycle");

   a_exc_set_in_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(exc_ff) |-> $past(st_ff == S_EVAL))
      else $error("exception mark set outside decode");

endmodule

`default_nettype wire

### hw/rtl/completion_event_tracker_unit.sv
// Top level of the completion event tracker: registers, sequencer and descriptor memory.
//
// Usage:
//  Request channel: an item is taken at a rising edge with start high and busy low.
//  Result channel: each item gives one result, shown on rsp_item for one cycle with
//  rsp_strobe high; the receiver cannot stall it, so it must take it in that cycle.
//  Configuration: APB-style port, register i at byte address 4*i, pready tied high;
//  write only while busy is low and no result is pending.
//  Steps (m = MOD_STEPS, the index reduction steps, 3 at 1024 entries):
//   init, tx, exception, clear and rejected rx items: decode, then the result.
//   read descriptor: decode, m reduction steps, the memory read, then the result.
//   rx completion covering d entries: decode, m reduction steps, one memory write per entry.
//   rx abort: decode, then two read-modify-write passes over the memory, each after m reduction steps.
//  A new item is accepted in the cycle its predecessor's result is shown.
//  Reset: synchronous; clears pointers, marks and the sequencer and restores the
//  register reset values. The descriptor memory is not cleared: an entry is valid
//  only after an rx completion wrote it.
`default_nettype none

module completion_event_tracker_unit
   import cet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_item_type          req_item,
   output logic                  rsp_strobe,
   output rsp_item_type          rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type            cfg;
   logic               mem_wr_en;
   logic [SLOT_W-1:0]  mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic               mem_rd_en;
   logic [SLOT_W-1:0]  mem_rd_addr;
   logic [ENTRY_W-1:0] mem_rd_data;

   cet_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cet_desc_ram #(
      .DEPTH (RING_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   cet_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .cfg         (cfg),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

### verif/tb_completion_event_tracker_unit.sv
// Self-checking testbench for completion_event_tracker_unit: directed and random event streams.
`default_nettype none

module tb_completion_event_tracker_unit;
   import cet_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 40;

   localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_item_type          req_item;
   logic                  rsp_strobe;
   rsp_item_type          rsp_item;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   cfg_type            ring_cfg;
   logic [ENTRY_W-1:0] desc_mem [RING_DEPTH];
   bit                 desc_written [RING_DEPTH];
   int unsigned        written_slots[$];
   logic [PTR_W-1:0]   rx_ptr;
   logic [PTR_W-1:0]   tx_ptr;
   logic               exc_mark;
   logic               started_mark;
   rsp_item_type       expected_q[$];
   int                 error_count;
   int                 cycle_count;
   int unsigned        idle_pct;

   completion_event_tracker_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, expected_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [PTR_W-1:0] ring_gap(input logic [PTR_W-1:0] idx, pend, mask);
      logic [PTR_W-1:0] stop_pos;
      logic [PTR_W-1:0] start_pos;
      stop_pos  = (idx + 1) & mask;
      start_pos = pend & mask;
      return (stop_pos >= start_pos) ? stop_pos - start_pos : mask + 1 - start_pos + stop_pos;
   endfunction

   function automatic rsp_item_type track_event(input req_item_type it);
      rsp_item_type     r;
      logic [PTR_W-1:0] mask;
      logic [PTR_W-1:0] gap;
      logic [PTR_W-1:0] pos;
      logic [ENTRY_W-1:0] entry;
      int unsigned      s;
      r = '0;
      case (it.req_type)
         REQ_INIT: begin
            started_mark = 1'b1;
         end
         REQ_RX: begin
            mask = PTR_W'(ring_cfg.rx_ring_mask);
            gap  = ring_gap(PTR_W'(it.desc_index), rx_ptr, mask);
            if (exc_mark) begin
               r.status = ST_IGN_IN_EXC;
            end else if (gap == 0 && it.length != 0) begin
               exc_mark = 1'b1;
               r.status = ST_BAD_ABORT;
            end else if (gap == 0) begin
               desc_mem[(rx_ptr & mask) % RING_DEPTH] |= ENTRY_W'(ring_cfg.discard_mask);
               desc_mem[(PTR_W'(it.desc_index) & mask) % RING_DEPTH] &=
                  ~ENTRY_W'(ring_cfg.continue_mask);
               r.status = ST_ABORT;
            end else if (gap > PTR_W'(ring_cfg.max_batch)) begin
               exc_mark = 1'b1;
               r.status = ST_OUT_OF_ORD;
            end else begin
               pos = rx_ptr & mask;
               repeat (gap) begin
                  s = pos % RING_DEPTH;
                  desc_mem[s] = {it.length, it.pkt_flags};
                  if (!desc_written[s]) begin
                     desc_written[s] = 1'b1;
                     written_slots.push_back(s);
                  end
                  pos = (pos + 1) & mask;
               end
               rx_ptr += gap;
               r.completed_count = CNT_W'(gap);
            end
         end
         REQ_TX: begin
            if (!ring_cfg.tx_enabled) begin
               r.status = ST_TX_IGNORED;
            end else begin
               gap = ring_gap(PTR_W'(it.desc_index), tx_ptr, PTR_W'(ring_cfg.tx_ring_mask));
               tx_ptr += gap;
               r.completed_count = CNT_W'(gap);
            end
         end
         REQ_EXC: begin
            if (it.exception_code == ring_cfg.ignored_exception_code) r.status = ST_EXC_IGNORED;
            else exc_mark = 1'b1;
         end
         REQ_READ: begin
            entry = desc_mem[PTR_W'(it.desc_index) % RING_DEPTH];
            r.desc_flags_out = entry[FLG_W-1:0];
            r.desc_size_out  = entry[ENTRY_W-1:FLG_W];
         end
         REQ_CLEAR: begin
            exc_mark = 1'b0;
         end
         default: begin
         end
      endcase
      r.rx_pending_count = rx_ptr;
      r.tx_pending_count = tx_ptr;
      r.exception_state  = exc_mark;
      r.started_state    = started_mark;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want, got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_item);
         end else begin
            want = expected_q.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_item.status));
            check_field("completed_count", 32'(want.completed_count),
                        32'(rsp_item.completed_count));
            check_field("rx_pending_count", want.rx_pending_count, rsp_item.rx_pending_count);
            check_field("tx_pending_count", want.tx_pending_count, rsp_item.tx_pending_count);
            check_field("exception_state", 32'(want.exception_state),
                        32'(rsp_item.exception_state));
            check_field("started_state", 32'(want.started_state), 32'(rsp_item.started_state));
            check_field("desc_flags_out", 32'(want.desc_flags_out), 32'(rsp_item.desc_flags_out));
            check_field("desc_size_out", 32'(want.desc_size_out), 32'(rsp_item.desc_size_out));
         end
      end
   end

   function automatic req_item_type event_of(input logic [REQ_W-1:0] kind,
                                             input logic [IDX_W-1:0] idx,
                                             input logic [LEN_W-1:0] len,
                                             input logic [FLG_W-1:0] flg,
                                             input logic [CODE_W-1:0] code);
      return {kind, idx, len, flg, code};
   endfunction

   // name the last entry of a batch of the given size from the rx pending pointer
   function automatic req_item_type rx_batch(input int unsigned gap,
                                             input logic [LEN_W-1:0] len,
                                             input logic [FLG_W-1:0] flg);
      logic [PTR_W-1:0] mask;
      logic [PTR_W-1:0] last;
      mask = PTR_W'(ring_cfg.rx_ring_mask);
      last = (((rx_ptr & mask) + gap - 1) & mask) | (PTR_W'($urandom) & ~mask);
      return event_of(REQ_RX, IDX_W'(last), len, flg, CODE_W'($urandom));
   endfunction

   function automatic req_item_type random_event();
      req_item_type     it;
      int unsigned      pick;
      int unsigned      room;
      int unsigned      mask;
      int unsigned      slot_sel;
      logic [LEN_W-1:0] len;
      logic [FLG_W-1:0] flg;
      len  = LEN_W'($urandom);
      flg  = FLG_W'($urandom);
      mask = ring_cfg.rx_ring_mask;
      room = (ring_cfg.max_batch < mask) ? ring_cfg.max_batch : mask;
      it   = event_of(REQ_INIT, IDX_W'($urandom), len, flg, CODE_W'($urandom));
      pick = $urandom_range(99);
      if (exc_mark && pick < 50) begin
         it.req_type = REQ_CLEAR;
      end else if (pick < 60) begin
         if (room == 0) it = rx_batch(0, '0, flg);
         else if ($urandom_range(9) == 0) it = rx_batch($urandom_range(1, room), len, flg);
         else it = rx_batch($urandom_range(1, (room < 8) ? room : 8), len, flg);
      end else if (pick < 67) begin
         it = rx_batch(0, ($urandom_range(3) == 0) ? len : '0, flg);
      end else if (pick < 70) begin
         if (room < mask) it = rx_batch($urandom_range(ring_cfg.max_batch + 1, mask), len, flg);
      end else if (pick < 80) begin
         if (written_slots.size() > 0) begin
            slot_sel = written_slots[$urandom_range(written_slots.size() - 1)];
            it.req_type   = REQ_READ;
            it.desc_index = IDX_W'(slot_sel) | (IDX_W'($urandom) & ~IDX_W'(RING_DEPTH - 1));
         end
      end else if (pick < 87) begin
         it.req_type = REQ_TX;
      end else if (pick < 92) begin
         it.req_type = REQ_EXC;
         if ($urandom_range(1) == 0) it.exception_code = ring_cfg.ignored_exception_code;
      end else if (pick < 95) begin
         it.req_type = REQ_CLEAR;
      end else if (pick < 97) begin
         it.req_type = REQ_INIT;
      end else begin
         it.req_type = ($urandom_range(1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
      end
      return it;
   endfunction

   task automatic send_event(input req_item_type it);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      expected_q.push_back(track_event(it));
   endtask

   task automatic wait_idle(input int unsigned extra);
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] reg_idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({reg_idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
   endtask

   task automatic write_rings(input logic [IDX_W-1:0] rx_mask, tx_mask,
                              input logic [CNT_W-1:0] batch,
                              input logic [FLG_W-1:0] discard, cont,
                              input logic [CODE_W-1:0] ign,
                              input logic tx_on);
      wait_idle(SETTLE_CYCLES);
      csr_write(REG_RX_MASK, 32'(rx_mask));
      csr_write(REG_TX_MASK, 32'(tx_mask));
      csr_write(REG_MAX_BAT, 32'(batch));
      csr_write(REG_DISCARD, 32'(discard));
      csr_write(REG_CONTINUE, 32'(cont));
      csr_write(REG_IGN_CODE, 32'(ign));
      csr_write(REG_TX_EN, 32'(tx_on));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      ring_cfg = {rx_mask, tx_mask, batch, discard, cont, ign, tx_on};
   endtask

   task automatic run_random(input int unsigned count, input bit with_gaps);
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 40 == 0) idle_pct = (with_gaps && $urandom_range(2) != 0) ? 30 : 0;
         send_event(random_event());
      end
   endtask

   task automatic test_directed_events();
      idle_pct = 25;
      send_event(event_of(REQ_INIT, 12'hFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_event(event_of(REQ_TX, 12'h005, 16'h0000, 16'h0000, 8'h00));
      send_event(event_of(REQ_EXC, 12'h000, 16'h0000, 16'h0000, 8'h00));
      send_event(event_of(REQ_EXC, 12'h000, 16'h0000, 16'h0000, 8'hFF));
      send_event(rx_batch(1, 16'h0010, 16'h0003));
      send_event(event_of(REQ_CLEAR, 12'h000, 16'h0000, 16'h0000, 8'h00));
      send_event(rx_batch(1, 16'hFFFF, 16'hFFFF));
      send_event(rx_batch(64, 16'h0000, 16'h0000));
      send_event(event_of(REQ_READ, 12'h000, 16'h0000, 16'h0000, 8'h00));
      send_event(event_of(REQ_READ, 12'hC40, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_event(rx_batch(1, 16'h00AB, 16'hFFFF));
      // abort names the entry just completed: its continue flag drops
      send_event(rx_batch(0, 16'h0000, 16'h1234));
      send_event(event_of(REQ_READ, 12'h441, 16'h0000, 16'h0000, 8'h00));
      send_event(rx_batch(0, 16'h0001, 16'h0000));
      send_event(event_of(REQ_CLEAR, 12'hFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_event(rx_batch(65, 16'h0100, 16'h0000));
      send_event(event_of(REQ_CLEAR, 12'h000, 16'h0000, 16'h0000, 8'h00));
      send_event(event_of(REQ_SPARE_LO, 12'hFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_event(event_of(REQ_SPARE_HI, 12'h000, 16'h0000, 16'h0000, 8'h00));
   endtask

   task automatic test_small_rings();
      write_rings(12'd7, 12'd7, 13'd8, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
      run_random(250, 1'b1);
   endtask

   task automatic test_zero_rings();
      write_rings(12'd0, 12'd0, 13'd1, 16'h0000, 16'h0000, 8'h5A, 1'b1);
      run_random(100, 1'b1);
   endtask

   task automatic test_full_rings();
      write_rings(12'd4095, 12'd4095, 13'd4096, FLG_W'($urandom), FLG_W'($urandom),
                  CODE_W'($urandom), 1'b1);
      run_random(60, 1'b1);
   endtask

   task automatic test_mixed_rings();
      write_rings(12'd31, 12'd255, 13'd16, 16'h8000, 16'h0001, CODE_W'($urandom), 1'b0);
      run_random(200, 1'b1);
   endtask

   task automatic test_uneven_masks();
      write_rings(12'd10, 12'd37, 13'd9, FLG_W'($urandom), FLG_W'($urandom),
                  CODE_W'($urandom), 1'b1);
      run_random(60, 1'b1);
   endtask

   task automatic test_drain_between_items();
      write_rings(12'd1023, 12'd511, 13'd64, 16'h0001, 16'h0002, 8'h00, 1'b1);
      idle_pct = 0;
      repeat (40) begin
         send_event(random_event());
         wait_idle(0);
      end
   endtask

   task automatic test_back_to_back();
      run_random(520, 1'b0);
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_item     = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      ring_cfg     = {12'd1023, 12'd1023, 13'd64, 16'd1, 16'd2, 8'd0, 1'b0};
      rx_ptr       = '0;
      tx_ptr       = '0;
      exc_mark     = 1'b0;
      started_mark = 1'b0;
      error_count  = 0;
      cycle_count  = 0;
      idle_pct     = 0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         desc_mem[i]     = '0;
         desc_written[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_events();
      test_small_rings();
      test_zero_rings();
      test_full_rings();
      test_mixed_rings();
      test_uneven_masks();
      test_drain_between_items();
      test_back_to_back();
      wait_idle(20);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
hw/rtl/cet_pkg.sv
hw/rtl/cet_regs.sv
hw/rtl/cet_desc_ram.sv
hw/rtl/cet_ctrl.sv
hw/rtl/completion_event_tracker_unit.sv
verif/tb_completion_event_tracker_unit.sv
